// ===== rtl/tis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// shared types and constants of the reservation station scheduler
// ----------------------------------------------------------------------------
package tis_pkg;

  localparam int MaxPerClass = 8;
  localparam int NumClasses  = 4;
  localparam int NumStations = NumClasses * MaxPerClass;
  localparam int NumRegs     = 32;
  localparam int StWidth     = $clog2(NumStations);

  // command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MULT  = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_LOAD  = 3'd5;
  localparam logic [2:0] CMD_STORE = 3'd6;

  // internal op codes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MULT  = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;
  localparam logic [2:0] OP_STORE = 3'd5;

  // event kinds
  localparam logic [2:0] EV_WRITE    = 3'd0;
  localparam logic [2:0] EV_EXEC     = 3'd1;
  localparam logic [2:0] EV_ISSUE    = 3'd2;
  localparam logic [2:0] EV_STALL_RS = 3'd3;
  localparam logic [2:0] EV_STALL_ID = 3'd4;
  localparam logic [2:0] EV_IDLE     = 3'd5;

  // register indexes
  localparam logic [2:0] CFG_LOAD_ST  = 3'd0;
  localparam logic [2:0] CFG_STORE_ST = 3'd1;
  localparam logic [2:0] CFG_ADD_ST   = 3'd2;
  localparam logic [2:0] CFG_MULT_ST  = 3'd3;
  localparam logic [2:0] CFG_ADD_LAT  = 3'd4;
  localparam logic [2:0] CFG_MULT_LAT = 3'd5;
  localparam logic [2:0] CFG_DIV_LAT  = 3'd6;
  localparam logic [2:0] CFG_MEM_LAT  = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] dest_reg;
    logic       src_j_is_reg;
    logic [4:0] src_j_reg;
    logic       src_k_is_reg;
    logic [4:0] src_k_reg;
  } instr_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] instr_id;
    logic [31:0] cycle_stamp;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [NumClasses-1:0][3:0] st_count;
    logic [5:0] lat_add;
    logic [5:0] lat_mult;
    logic [5:0] lat_div;
    logic [5:0] lat_mem;
  } cfg_t;

endpackage

// ===== rtl/tis_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_front
// accepts tick items and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module tis_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tis_pkg::instr_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output tis_pkg::instr_t q_item
);
  import tis_pkg::*;

  instr_t mem_r [2];
  logic   wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic   push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/tis_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_back
// station array and sequencer: runs one tick and emits its events one by one
// ----------------------------------------------------------------------------
module tis_back (
  input  logic             clk,
  input  logic             rst_n,
  input  tis_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  tis_pkg::instr_t  q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output tis_pkg::event_t  out_ev
);
  import tis_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_BCAST, S_EXEC, S_SCAN, S_ISSUE, S_WAIT} state_t;

  state_t state_r;
  instr_t item_r;
  logic [NumStations-1:0] busy_r, jrdy_r, krdy_r;
  logic [StWidth-1:0] jtag_r [NumStations];
  logic [StWidth-1:0] ktag_r [NumStations];
  logic [2:0]  op_r    [NumStations];
  logic [5:0]  cnt_r   [NumStations];
  logic [15:0] id_r    [NumStations];
  logic [NumRegs-1:0] rprod_r, rrdy_r;
  logic [StWidth-1:0] rtag_r [NumRegs];
  logic [16:0] next_id_r;
  logic [31:0] tick_r;
  logic [31:0] stamp_r;
  logic        bus_v_r;
  logic [StWidth-1:0] bus_tag_r;
  logic [NumStations-1:0] fin_r;
  logic        ev_v_r;
  event_t      ev_r;

  // per-station latency and completion
  logic [5:0] lat [NumStations];
  logic [NumStations-1:0] done;
  always_comb begin
    for (int s = 0; s < NumStations; s++) begin
      case (op_r[s])
        OP_ADD, OP_SUB: lat[s] = cfg.lat_add;
        OP_MULT:        lat[s] = cfg.lat_mult;
        OP_DIV:         lat[s] = cfg.lat_div;
        default:        lat[s] = cfg.lat_mem;
      endcase
      if (lat[s] == 6'd0) lat[s] = 6'd1;
      done[s] = busy_r[s] && (cnt_r[s] >= lat[s]);
    end
  end

  // oldest completed station: registered tree, two levels per pass
  logic [15:0] l1_id [8];
  logic [StWidth-1:0] l1_tag [8];
  logic [7:0] l1_v;
  logic [15:0] l1_id_r [8];
  logic [StWidth-1:0] l1_tag_r [8];
  logic [7:0] l1_v_r;
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      l1_v[g] = 1'b0;
      l1_id[g] = '0;
      l1_tag[g] = '0;
      for (int e = 0; e < 4; e++) begin
        if (done[g*4+e] && (!l1_v[g] || id_r[g*4+e] < l1_id[g])) begin
          l1_v[g] = 1'b1;
          l1_id[g] = id_r[g*4+e];
          l1_tag[g] = StWidth'(g*4+e);
        end
      end
    end
  end
  logic best_v;
  logic [15:0] best_id;
  logic [StWidth-1:0] best_tag;
  always_comb begin
    best_v = 1'b0;
    best_id = '0;
    best_tag = '0;
    for (int g = 0; g < 8; g++) begin
      if (l1_v_r[g] && (!best_v || l1_id_r[g] < best_id)) begin
        best_v = 1'b1;
        best_id = l1_id_r[g];
        best_tag = l1_tag_r[g];
      end
    end
  end

  // first pending executed event
  logic fin_any;
  logic [StWidth-1:0] fin_idx;
  always_comb begin
    fin_any = 1'b0;
    fin_idx = '0;
    for (int s = NumStations-1; s >= 0; s--) begin
      if (fin_r[s]) begin
        fin_any = 1'b1;
        fin_idx = StWidth'(s);
      end
    end
  end

  // issue decode
  logic [2:0] iop;
  logic [1:0] icls;
  logic [3:0] icount;
  logic       islot_v;
  logic [StWidth-1:0] islot;
  logic       jr, kr;
  logic [StWidth-1:0] jt, kt;
  logic [4:0] jreg;
  always_comb begin
    iop = item_r.cmd - 3'd1;
    case (iop)
      OP_ADD, OP_SUB:  icls = 2'd2;
      OP_MULT, OP_DIV: icls = 2'd3;
      OP_LOAD:         icls = 2'd0;
      default:         icls = 2'd1;
    endcase
    icount = cfg.st_count[icls];
    if (icount > 4'(MaxPerClass)) icount = 4'(MaxPerClass);
    islot_v = 1'b0;
    islot = '0;
    for (int i = MaxPerClass-1; i >= 0; i--) begin
      if (4'(i) < icount && !busy_r[{icls, 3'(i)}]) begin
        islot_v = 1'b1;
        islot = {icls, 3'(i)};
      end
    end
    jreg = (iop == OP_STORE) ? item_r.dest_reg : item_r.src_j_reg;
    jr = 1'b1;
    jt = '0;
    if (iop == OP_STORE || item_r.src_j_is_reg) begin
      if (rprod_r[jreg] && !rrdy_r[jreg]) begin
        jr = 1'b0;
        jt = rtag_r[jreg];
      end
    end
    kr = 1'b1;
    kt = '0;
    if (item_r.src_k_is_reg) begin
      if (rprod_r[item_r.src_k_reg] && !rrdy_r[item_r.src_k_reg]) begin
        kr = 1'b0;
        kt = rtag_r[item_r.src_k_reg];
      end
    end
  end

  logic ev_free;
  assign ev_free   = !ev_v_r || out_ready;
  assign out_valid = ev_v_r;
  assign out_ev    = ev_r;
  assign q_ready   = (state_r == S_IDLE);

  // payload stores
  always_ff @(posedge clk) begin
    l1_id_r  <= l1_id;
    l1_tag_r <= l1_tag;
    if (state_r == S_IDLE && q_valid) item_r <= q_item;
    if (state_r == S_EXEC) begin
      for (int s = 0; s < NumStations; s++) begin
        if (busy_r[s] && !(jrdy_r[s] && krdy_r[s]) && bus_v_r) begin
          if (!jrdy_r[s] && jtag_r[s] == bus_tag_r) jrdy_r[s] <= 1'b1;
          if (!krdy_r[s] && ktag_r[s] == bus_tag_r) krdy_r[s] <= 1'b1;
        end
        if (busy_r[s] && jrdy_r[s] && krdy_r[s] && cnt_r[s] < lat[s]) begin
          cnt_r[s] <= cnt_r[s] + 6'd1;
        end
      end
      if (bus_v_r) begin
        for (int r = 0; r < NumRegs; r++) begin
          if (rprod_r[r] && !rrdy_r[r] && rtag_r[r] == bus_tag_r) rrdy_r[r] <= 1'b1;
        end
      end
    end
    if (state_r == S_ISSUE && ev_free && item_r.cmd >= CMD_ADD && item_r.cmd <= CMD_STORE
        && !next_id_r[16] && islot_v) begin
      op_r[islot]  <= iop;
      cnt_r[islot] <= 6'd0;
      id_r[islot]  <= next_id_r[15:0];
      jrdy_r[islot] <= jr;
      krdy_r[islot] <= kr;
      if (!jr) jtag_r[islot] <= jt;
      if (!kr) ktag_r[islot] <= kt;
      if (iop != OP_STORE) begin
        rrdy_r[item_r.dest_reg] <= 1'b0;
        rtag_r[item_r.dest_reg] <= islot;
      end
    end
    if (!rst_n) begin
      jrdy_r <= '0;
      krdy_r <= '0;
      rrdy_r <= '0;
      for (int s = 0; s < NumStations; s++) begin
        cnt_r[s] <= '0;
        op_r[s] <= '0;
        id_r[s] <= '0;
      end
      for (int r = 0; r < NumRegs; r++) rtag_r[r] <= '0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= '0;
      rprod_r <= '0;
      next_id_r <= '0;
      tick_r <= '0;
      stamp_r <= '0;
      bus_v_r <= 1'b0;
      bus_tag_r <= '0;
      fin_r <= '0;
      ev_v_r <= 1'b0;
      ev_r <= '0;
      l1_v_r <= '0;
    end else begin
      l1_v_r <= l1_v;
      if (ev_v_r && out_ready) ev_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            stamp_r <= (tick_r == '1) ? tick_r : tick_r + 32'd1;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: state_r <= S_BCAST;
        S_BCAST: begin
          if (ev_free) begin
            bus_v_r <= best_v;
            bus_tag_r <= best_tag;
            if (best_v) begin
              busy_r[best_tag] <= 1'b0;
              ev_v_r <= 1'b1;
              ev_r <= '{EV_WRITE, best_id, stamp_r, 1'b0};
            end
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          for (int s = 0; s < NumStations; s++) begin
            fin_r[s] <= busy_r[s] && jrdy_r[s] && krdy_r[s]
                        && (cnt_r[s] < lat[s]) && (cnt_r[s] + 6'd1 == lat[s]);
          end
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (ev_free) begin
            if (fin_any) begin
              fin_r[fin_idx] <= 1'b0;
              ev_v_r <= 1'b1;
              ev_r <= '{EV_EXEC, id_r[fin_idx], stamp_r, 1'b0};
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (ev_free) begin
            ev_v_r <= 1'b1;
            if (item_r.cmd < CMD_ADD || item_r.cmd > CMD_STORE) begin
              ev_r <= '{EV_IDLE, 16'd0, stamp_r, 1'b1};
            end else if (next_id_r[16]) begin
              ev_r <= '{EV_STALL_ID, 16'd0, stamp_r, 1'b1};
            end else if (!islot_v) begin
              ev_r <= '{EV_STALL_RS, 16'd0, stamp_r, 1'b1};
            end else begin
              ev_r <= '{EV_ISSUE, next_id_r[15:0], stamp_r, 1'b1};
              busy_r[islot] <= 1'b1;
              if (iop != OP_STORE) rprod_r[item_r.dest_reg] <= 1'b1;
              next_id_r <= next_id_r + 17'd1;
            end
            if (tick_r != '1) tick_r <= tick_r + 32'd1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/tomasulo_issue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tomasulo_issue_scheduler
// reservation station timing model: one tick item in, its events out
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata: cmd, dest_reg, src_j_is_reg, src_j_reg, src_k_is_reg, src_k_reg
// out_    | out | tdata: event_kind, instr_id, cycle_stamp; tlast: last
// cfg_    | in  | index 3 bits, data 6 bits
// a tick steps the sequencer through wait, broadcast, execute, scan and issue; scan repeats per executed event
// the station search uses a two-level registered tree, hence the wait step
// reset clears all stations and register status at once
// output stalls hold the sequencer; the input queue holds two items
module tomasulo_issue_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd, dest_reg, src_j_is_reg, src_j_reg, src_k_is_reg, src_k_reg
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // event_kind, instr_id, cycle_stamp
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import tis_pkg::*;

  instr_t in_item, q_item;
  logic   q_valid, q_ready;
  event_t ev;
  cfg_t   cfg_r;

  assign in_item.cmd          = in_tdata[2:0];
  assign in_item.dest_reg     = in_tdata[7:3];
  assign in_item.src_j_is_reg = in_tdata[8];
  assign in_item.src_j_reg    = in_tdata[13:9];
  assign in_item.src_k_is_reg = in_tdata[14];
  assign in_item.src_k_reg    = in_tdata[19:15];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.st_count[0] <= 4'd3;
      cfg_r.st_count[1] <= 4'd3;
      cfg_r.st_count[2] <= 4'd3;
      cfg_r.st_count[3] <= 4'd2;
      cfg_r.lat_add  <= 6'd2;
      cfg_r.lat_mult <= 6'd10;
      cfg_r.lat_div  <= 6'd40;
      cfg_r.lat_mem  <= 6'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOAD_ST:  cfg_r.st_count[0] <= cfg_data[3:0];
        CFG_STORE_ST: cfg_r.st_count[1] <= cfg_data[3:0];
        CFG_ADD_ST:   cfg_r.st_count[2] <= cfg_data[3:0];
        CFG_MULT_ST:  cfg_r.st_count[3] <= cfg_data[3:0];
        CFG_ADD_LAT:  cfg_r.lat_add  <= cfg_data;
        CFG_MULT_LAT: cfg_r.lat_mult <= cfg_data;
        CFG_DIV_LAT:  cfg_r.lat_div  <= cfg_data;
        CFG_MEM_LAT:  cfg_r.lat_mem  <= cfg_data;
        default: ;
      endcase
    end
  end

  tis_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  tis_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_ready, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_ev(ev)
  );

  assign out_tdata = {5'd0, ev.cycle_stamp, ev.instr_id, ev.event_kind};
  assign out_tlast = ev.last;
endmodule

// ===== rtl/tis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_checker
// port-level checks on the scheduler result stream
// ----------------------------------------------------------------------------
module tis_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);
  import tis_pkg::*;

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");
  // tick-closing kinds carry last
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[2:0] != EV_WRITE && out_tdata[2:0] != EV_EXEC)))
    else $error("last flag does not match event kind");
  // stall and idle carry a zero id
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == EV_STALL_RS || out_tdata[2:0] == EV_STALL_ID ||
                   out_tdata[2:0] == EV_IDLE)
    |-> out_tdata[18:3] == 16'd0)
    else $error("stall event with nonzero id");
endmodule

bind tomasulo_issue_scheduler tis_checker u_tis_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
